@@ rtl/png_text_chunk_extractor_macros.svh @@
// assertion helpers shared by pte_front and pte_queue
`ifndef PNG_TEXT_CHUNK_EXTRACTOR_MACROS_SVH
`define PNG_TEXT_CHUNK_EXTRACTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pte assertion failed");

// next-cycle implication, checked out of reset
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pte assertion failed");

`endif

@@ rtl/pte_pkg.sv @@
package pte_pkg;

  // tags matched against the byte window
  localparam logic [31:0] TagIhdr  = 32'h49484452;
  localparam logic [31:0] TagText  = 32'h74455874;
  localparam logic [31:0] TagItxt  = 32'h69545874;
  localparam logic [39:0] TagIdatx = 40'h4944415478;

  localparam logic [2:0] ItxtSkip   = 3'd4;
  localparam logic [2:0] CheckGuard = 3'd3;
  localparam logic [2:0] ResumeMax  = 3'd7;

  // result queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    PH_SEEK    = 3'd0,
    PH_SCAN    = 3'd1,
    PH_KEY     = 3'd2,
    PH_SKIP    = 3'd3,
    PH_VALUE   = 3'd4,
    PH_DRAIN   = 3'd5,
    PH_ENDMARK = 3'd6,
    PH_STOP    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_KEY       = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_ENTRY_END = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_DONE      = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text_byte;
  } pte_res_t;

  // queue status seen by the top-level input gate and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } pte_qstat_t;

endpackage

@@ rtl/pte_front.sv @@
`include "png_text_chunk_extractor_macros.svh"

module pte_front import pte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       push_o,
  output pte_res_t   res_o
);

  logic [63:0] win_q, win_d;
  phase_e      phase_q, phase_d;
  logic [31:0] remain_q, remain_d;
  logic        intl_q, intl_d;
  logic [2:0]  skip_q, skip_d;
  logic [2:0]  guard_q, guard_d;
  logic [2:0]  resume_q, resume_d;

  logic [63:0] win_new;
  logic [31:0] low32;
  logic [31:0] remain_dec;
  logic [2:0]  resume_inc;
  logic [2:0]  skip_dec;
  logic        err;
  logic        emit;
  kind_e       kind;
  logic [7:0]  tbyte;

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      phase_q  <= PH_SEEK;
      remain_q <= '0;
      intl_q   <= 1'b0;
      skip_q   <= '0;
      guard_q  <= '0;
      resume_q <= '0;
    end else if (acc_i) begin
      win_q    <= win_d;
      phase_q  <= phase_d;
      remain_q <= remain_d;
      intl_q   <= intl_d;
      skip_q   <= skip_d;
      guard_q  <= guard_d;
      resume_q <= resume_d;
    end
  end

  assign win_new    = {win_q[55:0], data_byte_i};
  assign low32      = win_new[31:0];
  assign remain_dec = remain_q - 32'd1;
  assign resume_inc = (resume_q < ResumeMax) ? resume_q + 3'd1 : resume_q;
  assign skip_dec   = skip_q - 3'd1;

  // classify one byte and step the phase
  always_comb begin
    win_d    = win_new;
    phase_d  = phase_q;
    remain_d = remain_q;
    intl_d   = intl_q;
    skip_d   = skip_q;
    guard_d  = guard_q;
    resume_d = resume_q;
    err      = 1'b0;
    emit     = 1'b0;
    kind     = KIND_KEY;
    tbyte    = data_byte_i;
    case (phase_q)
      PH_SEEK: begin
        if (low32 == TagIhdr) begin
          phase_d  = PH_SCAN;
          resume_d = 3'd4;
          guard_d  = '0;
        end
      end
      PH_SCAN: begin
        if (guard_q != 3'd0) begin
          err     = 1'b1;
          guard_d = guard_q - 3'd1;
        end
        resume_d = resume_inc;
        if (resume_inc >= 3'd5 && win_new[39:0] == TagIdatx) begin
          phase_d = PH_STOP;
        end else if (resume_inc >= 3'd4 && (low32 == TagText || low32 == TagItxt)) begin
          err      = 1'b1;
          intl_d   = (low32 == TagItxt);
          remain_d = win_new[63:32];
          phase_d  = (win_new[63:32] == 32'd0) ? PH_ENDMARK : PH_KEY;
        end
      end
      PH_KEY: begin
        err = 1'b1;
        if (data_byte_i == 8'd0) begin
          if (intl_q) begin
            skip_d  = ItxtSkip;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_VALUE;
          end
        end else begin
          emit = 1'b1;
          kind = KIND_KEY;
        end
        remain_d = remain_dec;
        if (remain_dec == 32'd0) phase_d = PH_ENDMARK;
      end
      PH_SKIP: begin
        err    = 1'b1;
        skip_d = skip_dec;
        if (skip_dec == 3'd0) phase_d = PH_VALUE;
        remain_d = remain_dec;
        if (remain_dec == 32'd0) phase_d = PH_ENDMARK;
      end
      PH_VALUE: begin
        err = 1'b1;
        if (data_byte_i == 8'd0) begin
          phase_d = PH_DRAIN;
        end else begin
          emit = 1'b1;
          kind = KIND_VALUE;
        end
        remain_d = remain_dec;
        if (remain_dec == 32'd0) phase_d = PH_ENDMARK;
      end
      PH_DRAIN: begin
        err      = 1'b1;
        remain_d = remain_dec;
        if (remain_dec == 32'd0) phase_d = PH_ENDMARK;
      end
      PH_ENDMARK: begin
        err      = 1'b1;
        emit     = 1'b1;
        kind     = KIND_ENTRY_END;
        tbyte    = 8'd0;
        phase_d  = PH_SCAN;
        guard_d  = CheckGuard;
        resume_d = '0;
        skip_d   = '0;
      end
      default: begin
      end
    endcase
    // end of file overrides and restarts
    if (end_of_file_i) begin
      emit     = 1'b1;
      kind     = err ? KIND_ERROR : KIND_DONE;
      tbyte    = 8'd0;
      win_d    = '0;
      phase_d  = PH_SEEK;
      remain_d = '0;
      intl_d   = 1'b0;
      skip_d   = '0;
      guard_d  = '0;
      resume_d = '0;
    end
  end

  assign push_o          = acc_i && emit;
  assign res_o.kind      = kind;
  assign res_o.text_byte = tbyte;

  `PTE_ASSERT_IMPLY(a_stop_silent, clk_i, rst_ni,
    acc_i && phase_q == PH_STOP && !end_of_file_i, !push_o)
  `PTE_ASSERT_IMPLY(a_eof_pushes, clk_i, rst_ni,
    acc_i && end_of_file_i, push_o && (res_o.kind == KIND_ERROR || res_o.kind == KIND_DONE))
  `PTE_ASSERT_NEXT(a_eof_restarts, clk_i, rst_ni,
    acc_i && end_of_file_i, phase_q == PH_SEEK && win_q == 64'd0)

endmodule

@@ rtl/pte_queue.sv @@
`include "png_text_chunk_extractor_macros.svh"

module pte_queue import pte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pte_res_t   push_data_i,
  input  logic       pop_i,
  output pte_res_t   pop_data_o,
  output pte_qstat_t stat_o
);

  pte_res_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign pop_data_o       = mem_q[rd_q];
  assign stat_o.full      = (cnt_q == QCntW'(QDepth));
  assign stat_o.not_empty = (cnt_q != '0);

  `PTE_ASSERT_IMPLY(a_no_overflow, clk_i, rst_ni, stat_o.full, !push_i || pop_i)
  `PTE_ASSERT_IMPLY(a_no_underflow, clk_i, rst_ni, pop_i, stat_o.not_empty)
  `PTE_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push_i && !pop_i, stat_o.not_empty)

endmodule

@@ rtl/pte_back.sv @@
module pte_back import pte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pte_qstat_t qstat_i,
  input  pte_res_t   q_data_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output pte_res_t   out_res_o
);

  logic     vld_q, vld_d;
  pte_res_t res_q;
  logic     take;

  // output register refills when empty or when its beat is taken
  assign take  = !vld_q || !out_stall_i;
  assign pop_o = take && qstat_i.not_empty;
  assign vld_d = take ? qstat_i.not_empty : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= q_data_i;
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule

@@ rtl/png_text_chunk_extractor.sv @@
// channel | dir | valid      | stall       | payload
// input   | in  | in_valid_i | in_stall_o  | data_byte_i, end_of_file_i
// output  | out | out_valid_o| out_stall_i | kind_o, text_byte_o
//
// one file byte per cycle while the result queue is not full; the parse front decides
// each byte in the cycle it is taken; a result passes through a two-entry queue and
// then the output register
// input stalls only while the result queue is full
// reset puts the parser in the state of waiting for the header tag

module png_text_chunk_extractor import pte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] text_byte_o
);

  logic       acc;
  logic       push;
  logic       pop;
  pte_res_t   push_data;
  pte_res_t   q_data;
  pte_res_t   out_res;
  pte_qstat_t qstat;

  assign in_stall_o = qstat.full;
  assign acc        = in_valid_i && !qstat.full;

  // parse front
  pte_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (push),
    .res_o         (push_data)
  );

  // result queue
  pte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .stat_o      (qstat)
  );

  // output stage
  pte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res)
  );

  assign kind_o      = out_res.kind;
  assign text_byte_o = out_res.text_byte;

endmodule
